/* hw/rtl/modulo_predicate_join_defines.svh */
// Assertion macros for the top RTL file of the modulo predicate join.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef MODULO_PREDICATE_JOIN_DEFINES_SVH
`define MODULO_PREDICATE_JOIN_DEFINES_SVH

// A property that holds on every clock edge outside reset.
`define MPJ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define MPJ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/mpj_pkg.sv */
package mpj_pkg;

  localparam int DATA_W      = 32;
  localparam int SIDX_W      = 6;
  localparam int ROW_W       = 2 * DATA_W;
  localparam int S_DEPTH_DEF = 64;

  localparam int IN_TDATA_W  = ((3 * DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + SIDX_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - SIDX_W;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_PROBE = 2'd2
  } cmd_t;

  // One checked S row as it leaves the remainder pipeline.
  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [SIDX_W-1:0] idx;
  } row_res_t;

endpackage

/* hw/rtl/mpj_ram.sv */
module mpj_ram #(
  parameter int WIDTH = mpj_pkg::ROW_W,
  parameter int DEPTH = mpj_pkg::S_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/mpj_rem_pipe.sv */
module mpj_rem_pipe (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_vld,
  input  logic [mpj_pkg::ROW_W-1:0]   in_row,
  input  logic [mpj_pkg::SIDX_W-1:0]  in_idx,
  input  logic [mpj_pkg::DATA_W-1:0]  dividend,
  output mpj_pkg::row_res_t           res,
  output logic                        busy
);

  localparam int DW     = mpj_pkg::DATA_W;
  localparam int STAGES = mpj_pkg::DATA_W;

  // One restoring step: bring in the next dividend bit and subtract if it fits.
  function automatic logic [DW-1:0] rem_step(input logic [DW-1:0] rem,
                                             input logic          dbit,
                                             input logic [DW-1:0] div);
    logic [DW:0] trial;
    logic [DW:0] diff;
    trial = {rem, dbit};
    diff  = trial - {1'b0, div};
    if (trial >= {1'b0, div}) begin
      rem_step = diff[DW-1:0];
    end else begin
      rem_step = trial[DW-1:0];
    end
  endfunction

  logic [STAGES-1:0]         st_vld;
  logic [DW-1:0]             st_rem [STAGES];
  logic [DW-1:0]             st_div [STAGES];
  logic [DW-1:0]             st_exp [STAGES];
  logic [mpj_pkg::SIDX_W-1:0] st_idx [STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld <= '0;
    end else if (adv) begin
      st_vld <= {st_vld[STAGES-2:0], in_vld};
    end
  end

  // Stage k handles dividend bit DW-1-k; the dividend is held for the whole probe.
  always_ff @(posedge clk) begin
    if (adv) begin
      st_rem[0] <= rem_step('0, dividend[DW-1], in_row[DW-1:0]);
      st_div[0] <= in_row[DW-1:0];
      st_exp[0] <= in_row[mpj_pkg::ROW_W-1:DW];
      st_idx[0] <= in_idx;
      for (int k = 1; k < STAGES; k++) begin
        st_rem[k] <= rem_step(st_rem[k-1], dividend[DW-1-k], st_div[k-1]);
        st_div[k] <= st_div[k-1];
        st_exp[k] <= st_exp[k-1];
        st_idx[k] <= st_idx[k-1];
      end
    end
  end

  always_comb begin
    res.vld = st_vld[STAGES-1];
    res.hit = (st_div[STAGES-1] != '0) && (st_rem[STAGES-1] == st_exp[STAGES-1]);
    res.idx = st_idx[STAGES-1];
    busy    = |st_vld;
  end

endmodule

/* hw/rtl/mpj_collect.sv */
module mpj_collect (
  input  logic                            clk,
  input  logic                            rst,
  input  mpj_pkg::row_res_t               res,
  input  logic                            flush,
  input  logic [mpj_pkg::DATA_W-1:0]      r_index,
  output logic                            out_free,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mpj_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tuser,
  output logic                            m_tlast
);

  logic                       held_vld;
  logic [mpj_pkg::SIDX_W-1:0] held_idx;

  assign out_free = !m_tvalid || m_tready;

  // A match is held back one step so that the final one can carry last.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      held_vld <= 1'b0;
    end else if (out_free) begin
      if (flush) begin
        m_tvalid <= 1'b1;
        held_vld <= 1'b0;
      end else if (res.vld && res.hit) begin
        m_tvalid <= held_vld;
        held_vld <= 1'b1;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (flush) begin
        m_tdata <= {{mpj_pkg::OUT_PAD_W{1'b0}},
                    (held_vld ? held_idx : {mpj_pkg::SIDX_W{1'b0}}), r_index};
        m_tuser <= held_vld;
        m_tlast <= 1'b1;
      end else if (res.vld && res.hit) begin
        m_tdata  <= {{mpj_pkg::OUT_PAD_W{1'b0}}, held_idx, r_index};
        m_tuser  <= 1'b1;
        m_tlast  <= 1'b0;
        held_idx <= res.idx;
      end
    end
  end

endmodule

/* hw/rtl/modulo_predicate_join.sv */
// Nested-loop join for the predicate R.a mod S.b == S.c.
// Input channel s_*: tuser carries the command (clear, load, probe), tdata the
// R.a value, S divisor and S remainder. Clear and load keep the input ready;
// a load into a full table is dropped. The S table sits in one synchronous RAM.
// A probe reads the stored rows in load order, one per cycle unless m_tready
// stalls, into a 32-stage restoring remainder pipeline that retires one bit per
// stage. Results leave on m_*: tdata holds the R index and S index, tuser the
// matched flag, tlast marks the final item of the probe; a probe without a match
// yields one unmatched item. A probe occupies the block through the row reads,
// the RAM read, the pipeline and the final flush, or only the drain and flush on
// an empty table; the input is not ready during that time. A stall on m_tready
// freezes the RAM read stage and the whole pipeline, so no item is lost. Reset
// empties the table, zeroes the R counter and drops any result in flight;
// s_tready stays low during reset and rises as soon as reset is released.
`include "modulo_predicate_join_defines.svh"

module modulo_predicate_join #(
  parameter int S_DEPTH = mpj_pkg::S_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // r_value [31:0], s_divisor [63:32], s_remainder [95:64]
  input  logic [mpj_pkg::IN_TDATA_W-1:0]  s_tdata,
  // cmd [1:0]
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // r_index [31:0], s_index [37:32], zero fill [39:38]
  output logic [mpj_pkg::OUT_TDATA_W-1:0] m_tdata,
  // matched [0]
  output logic                            m_tuser,
  output logic                            m_tlast
);

  localparam int DW = mpj_pkg::DATA_W;
  localparam int AW = (S_DEPTH > 1) ? $clog2(S_DEPTH) : 1;
  localparam int CW = $clog2(S_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(S_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t                 state;
  logic [CW-1:0]          s_count;
  logic [DW-1:0]          r_counter;
  logic [CW-1:0]          rd_idx;
  logic [CW-1:0]          d_idx;
  logic                   d_vld;
  logic [DW-1:0]          probe_value;
  logic [DW-1:0]          probe_index;

  logic                   in_acc;
  logic                   out_free;
  logic                   pipe_busy;
  logic                   ram_we;
  logic [AW-1:0]          ram_raddr;
  logic [mpj_pkg::ROW_W-1:0] ram_rdata;
  mpj_pkg::row_res_t      res;
  logic                   flush;
  logic                   unmatched_ok;

  assign s_tready = (state == ST_IDLE) && !rst;
  assign in_acc   = s_tvalid && s_tready;
  assign ram_we   = in_acc && (s_tuser == mpj_pkg::CMD_LOAD) && (s_count < DEPTH_CNT);
  assign flush    = (state == ST_FLUSH);

  // The read address holds on a stall so that the RAM output keeps matching d_idx.
  assign ram_raddr = out_free ? rd_idx[AW-1:0] : d_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      s_count   <= '0;
      r_counter <= '0;
      d_vld     <= 1'b0;
    end else begin
      if (out_free) begin
        d_vld <= (state == ST_ISSUE);
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (s_tuser)
              mpj_pkg::CMD_CLEAR: begin
                s_count   <= '0;
                r_counter <= '0;
              end
              mpj_pkg::CMD_LOAD: begin
                if (s_count < DEPTH_CNT) begin
                  s_count <= s_count + 1'b1;
                end
              end
              mpj_pkg::CMD_PROBE: begin
                if (r_counter != '1) begin
                  r_counter <= r_counter + 1'b1;
                end
                state <= (s_count == '0) ? ST_DRAIN : ST_ISSUE;
              end
              default: ;
            endcase
          end
        end
        ST_ISSUE: begin
          if (out_free && (rd_idx + 1'b1 == s_count)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!d_vld && !pipe_busy) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (s_tuser == mpj_pkg::CMD_PROBE)) begin
      probe_value <= s_tdata[DW-1:0];
      probe_index <= r_counter;
      rd_idx      <= '0;
    end else if ((state == ST_ISSUE) && out_free) begin
      rd_idx <= rd_idx + 1'b1;
    end
    if (out_free) begin
      d_idx <= rd_idx;
    end
  end

  mpj_ram #(
    .WIDTH (mpj_pkg::ROW_W),
    .DEPTH (S_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s_count[AW-1:0]),
    .wdata ({s_tdata[3*DW-1:2*DW], s_tdata[2*DW-1:DW]}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mpj_rem_pipe u_rem (
    .clk      (clk),
    .rst      (rst),
    .adv      (out_free),
    .in_vld   (d_vld),
    .in_row   (ram_rdata),
    .in_idx   (mpj_pkg::SIDX_W'(d_idx)),
    .dividend (probe_value),
    .res      (res),
    .busy     (pipe_busy)
  );

  mpj_collect u_collect (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .flush    (flush),
    .r_index  (probe_index),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // An unmatched item is always the final one and carries S index zero.
  assign unmatched_ok = m_tuser || (m_tlast && m_tdata[DW+mpj_pkg::SIDX_W-1:DW] == '0);

  `MPJ_ASSERT(a_idle_empty, s_tready |-> (!pipe_busy && !d_vld), "idle with rows in flight")
  `MPJ_ASSERT(a_issue_range, (state == ST_ISSUE) |-> (rd_idx < s_count), "read past stored rows")
  `MPJ_ASSERT(a_count_cap, s_count <= DEPTH_CNT, "table count beyond depth")
  `MPJ_ASSERT_NEXT(a_flush_last, flush && out_free, m_tvalid && m_tlast, "no final item")
  `MPJ_ASSERT(a_unmatched_form, m_tvalid |-> unmatched_ok, "malformed unmatched item")

endmodule
